@@ sv/ifps_pkg.sv @@
// shared constants, types and the default palette table for the indexed framebuffer scan-out
// no dependencies
package ifps_pkg;

  localparam int SCREEN_WIDTH    = 320;
  localparam int SCREEN_HEIGHT   = 480;
  localparam int PALETTE_ENTRIES = 256;

  localparam int PIXEL_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int PIX_AW          = $clog2(PIXEL_COUNT);
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int COL_W           = $clog2(SCREEN_WIDTH);
  localparam int ROW_W           = $clog2(SCREEN_HEIGHT);

  localparam int OPC_W           = 3;
  localparam int XY_W            = 9;
  localparam int IDX_W           = 8;
  localparam int COLOR_W         = 16;
  localparam int DEFAULT_COLORS  = 16;

  localparam logic [IDX_W-1:0] BLACK_INDEX = 8'd15;

  typedef enum logic [OPC_W-1:0] {
    OP_DRAW        = 3'd0,
    OP_PAL_WRITE   = 3'd1,
    OP_PAL_CLEAR   = 3'd2,
    OP_PAL_DEFAULT = 3'd3,
    OP_SCAN        = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [XY_W-1:0]    x;
    logic [XY_W-1:0]    y;
    logic [IDX_W-1:0]   color_index;
    logic [IDX_W-1:0]   palette_index;
    logic [COLOR_W-1:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [XY_W-1:0]    row;
    logic [XY_W-1:0]    column;
    logic               row_start;
    logic               frame_end;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic init_wr;
    logic draw;
    logic pal_wr;
    logic pal_clear;
    logic pal_default;
    logic scan_start;
    logic pal_rd;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic init_last;
    logic out_free;
  } status_t;

  function automatic logic [COLOR_W-1:0] default_color(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      8'd0:    c = 16'hFFFF;
      8'd1:    c = 16'hFFE0;
      8'd2:    c = 16'hFD20;
      8'd3:    c = 16'hF800;
      8'd4:    c = 16'hEC1D;
      8'd5:    c = 16'h4810;
      8'd6:    c = 16'h001F;
      8'd7:    c = 16'h05FF;
      8'd8:    c = 16'h3666;
      8'd9:    c = 16'h0320;
      8'd10:   c = 16'h8A22;
      8'd11:   c = 16'hD5B1;
      8'd12:   c = 16'hD69A;
      8'd13:   c = 16'hAD55;
      8'd14:   c = 16'h6B4D;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

@@ sv/ifps_if.sv @@
// valid/ready channel interfaces for the command input and the scan-out result
// depends on ifps_pkg
interface ifps_in_if import ifps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [XY_W-1:0]    x;
  logic [XY_W-1:0]    y;
  logic [IDX_W-1:0]   color_index;
  logic [IDX_W-1:0]   palette_index;
  logic [COLOR_W-1:0] palette_color;

  modport source (output valid, opcode, x, y, color_index, palette_index, palette_color,
                  input ready);
  modport sink   (input valid, opcode, x, y, color_index, palette_index, palette_color,
                  output ready);
endinterface

interface ifps_out_if import ifps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [XY_W-1:0]    row;
  logic [XY_W-1:0]    column;
  logic               row_start;
  logic               frame_end;

  modport source (output valid, pixel_color, row, column, row_start, frame_end,
                  input ready);
  modport sink   (input valid, pixel_color, row, column, row_start, frame_end,
                  output ready);
endinterface

@@ sv/indexed_framebuffer_palette_scanout.sv @@
// top level of the indexed framebuffer with palette lookup and scan-out
// depends on ifps_pkg, ifps_if, ifps_ram, ifps_ctrl and ifps_dp
//
//   channel   dir  fields
//   in_i      in   opcode, x, y, color_index, palette_index, palette_color
//   out_o     out  pixel_color, row, column, row_start, frame_end
//
// draw, palette write, palette clear and default restore may follow each other
// every cycle while no scan or clearing pass is in progress. a scan steps
// through the frame ram read, the palette ram read that depends on it and the
// load of the output register. after reset a clearing pass writes index 15 to
// all 153600 frame entries, one a cycle, with in_i.ready low. a scan result that
// finds the output register full waits in the palette step.
module indexed_framebuffer_palette_scanout import ifps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ifps_in_if.sink           in_i,
  ifps_out_if.source        out_o
);

  in_item_t  item;
  out_item_t out_item;
  cmd_t      cmd;
  status_t   status;
  logic      in_ready;
  logic      out_valid;

  assign item = '{
    opcode:        in_i.opcode,
    x:             in_i.x,
    y:             in_i.y,
    color_index:   in_i.color_index,
    palette_index: in_i.palette_index,
    palette_color: in_i.palette_color
  };

  ifps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .opcode_i   (in_i.opcode),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ifps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.pixel_color = out_item.pixel_color;
  assign out_o.row         = out_item.row;
  assign out_o.column      = out_item.column;
  assign out_o.row_start   = out_item.row_start;
  assign out_o.frame_end   = out_item.frame_end;

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while output register still full");

  // the palette read follows the frame read of a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_start |=> cmd.pal_rd)
    else $error("scan did not proceed to palette read");

  // no input transfer during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.init_wr |-> !in_ready)
    else $error("input ready during clearing pass");

  // at most one operation issued per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.init_wr, cmd.draw, cmd.pal_wr, cmd.pal_clear, cmd.pal_default,
              cmd.scan_start, cmd.pal_rd, cmd.out_load}))
    else $error("more than one command in a cycle");

endmodule

@@ sv/ifps_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ifps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ifps_ctrl.sv @@
// sequencer: clearing pass, opcode dispatch and the three-step scan-out
// depends on ifps_pkg
module ifps_ctrl import ifps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [OPC_W-1:0] opcode_i,
  output logic             in_ready_o,
  input  status_t          status_i,
  output cmd_t             cmd_o
);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_PIX  = 2'd2;
  localparam logic [1:0] S_PAL  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (opcode_e'(opcode_i))
            OP_DRAW:        cmd_o.draw        = 1'b1;
            OP_PAL_WRITE:   cmd_o.pal_wr      = 1'b1;
            OP_PAL_CLEAR:   cmd_o.pal_clear   = 1'b1;
            OP_PAL_DEFAULT: cmd_o.pal_default = 1'b1;
            OP_SCAN: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_PIX;
            end
            default: ;
          endcase
        end
      end
      S_PIX: begin
        cmd_o.pal_rd = 1'b1;
        state_d      = S_PAL;
      end
      S_PAL: begin
        // hold the palette word until the output register frees up
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/ifps_dp.sv @@
// datapath: frame ram, palette ram with valid bits, scan counters and output register
// depends on ifps_pkg and ifps_ram
module ifps_dp import ifps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // clearing pass
  logic [PIX_AW-1:0] init_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_addr_q <= '0;
    end else if (cmd_i.init_wr) begin
      init_addr_q <= init_addr_q + 1'b1;
    end
  end

  assign status_o.init_last = (init_addr_q == PIX_AW'(PIXEL_COUNT - 1));

  // frame ram
  logic              draw_ok;
  logic [PIX_AW-1:0] draw_addr;
  logic              fb_we;
  logic [PIX_AW-1:0] fb_waddr;
  logic [IDX_W-1:0]  fb_wdata;
  logic [IDX_W-1:0]  fb_rdata;
  logic [PIX_AW-1:0] scan_pos_q;

  assign draw_ok   = (32'(item_i.x) < SCREEN_WIDTH) && (32'(item_i.y) < SCREEN_HEIGHT);
  assign draw_addr = PIX_AW'(32'(item_i.y) * SCREEN_WIDTH + 32'(item_i.x));
  assign fb_we     = cmd_i.init_wr || (cmd_i.draw && draw_ok);
  assign fb_waddr  = cmd_i.init_wr ? init_addr_q : draw_addr;
  assign fb_wdata  = cmd_i.init_wr ? BLACK_INDEX : item_i.color_index;

  ifps_ram #(
    .WIDTH (IDX_W),
    .DEPTH (PIXEL_COUNT)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (fb_waddr),
    .wdata_i (fb_wdata),
    .re_i    (cmd_i.scan_start),
    .raddr_i (scan_pos_q),
    .rdata_o (fb_rdata)
  );

  // scan position
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             col_last, row_last;
  logic [XY_W-1:0]  meta_row_q, meta_col_q;
  logic             meta_start_q, meta_end_q;

  assign col_last = (col_q == COL_W'(SCREEN_WIDTH - 1));
  assign row_last = (row_q == ROW_W'(SCREEN_HEIGHT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      scan_pos_q <= '0;
    end else if (cmd_i.scan_start) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
      scan_pos_q <= (col_last && row_last) ? '0 : scan_pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      meta_row_q   <= XY_W'(row_q);
      meta_col_q   <= XY_W'(col_q);
      meta_start_q <= (col_q == '0);
      meta_end_q   <= col_last && row_last;
    end
  end

  // palette: entries without a valid bit read as the cleared or default table
  logic                       pal_ok;
  logic                       pal_we;
  logic [COLOR_W-1:0]         pal_rdata;
  logic [PALETTE_ENTRIES-1:0] pal_valid_q;
  logic                       base_default_q;
  logic [PAL_AW-1:0]          rd_idx;
  logic [IDX_W-1:0]           idx_q;
  logic                       idx_ok_q, hit_q;

  assign pal_ok = 32'(item_i.palette_index) < PALETTE_ENTRIES;
  assign pal_we = cmd_i.pal_wr && pal_ok;
  assign rd_idx = fb_rdata[PAL_AW-1:0];

  ifps_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (item_i.palette_index[PAL_AW-1:0]),
    .wdata_i (item_i.palette_color),
    .re_i    (cmd_i.pal_rd),
    .raddr_i (rd_idx),
    .rdata_o (pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_valid_q    <= '0;
      base_default_q <= 1'b1;
    end else if (cmd_i.pal_clear || cmd_i.pal_default) begin
      pal_valid_q    <= '0;
      base_default_q <= cmd_i.pal_default;
    end else if (pal_we) begin
      pal_valid_q[item_i.palette_index[PAL_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pal_rd) begin
      idx_q    <= fb_rdata;
      idx_ok_q <= 32'(fb_rdata) < PALETTE_ENTRIES;
      hit_q    <= pal_valid_q[rd_idx];
    end
  end

  logic [COLOR_W-1:0] color;

  always_comb begin
    if (!idx_ok_q) begin
      color = '0;
    end else if (hit_q) begin
      color = pal_rdata;
    end else if (base_default_q) begin
      color = default_color(idx_q);
    end else begin
      color = '0;
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_item_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.pixel_color <= color;
      out_item_q.row         <= meta_row_q;
      out_item_q.column      <= meta_col_q;
      out_item_q.row_start   <= meta_start_q;
      out_item_q.frame_end   <= meta_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ tb/tb_ifps_scan_pkg.sv @@
// scoreboard for the indexed framebuffer scan-out: frame and palette shadow plus pixel checks
// depends on ifps_pkg
package tb_ifps_scan_pkg;
  import ifps_pkg::*;

  class scan_scoreboard;
    logic [IDX_W-1:0]   frame_mem [PIXEL_COUNT];
    logic [COLOR_W-1:0] color_table [PALETTE_ENTRIES];
    logic [COL_W-1:0]   scan_col;
    logic [ROW_W-1:0]   scan_row;
    out_item_t          expected_pixels [$];
    int                 mismatch_count;

    function new();
      foreach (frame_mem[i]) frame_mem[i] = BLACK_INDEX;
      load_default_palette();
      scan_col = '0;
      scan_row = '0;
      mismatch_count = 0;
    endfunction

    function void load_default_palette();
      logic [COLOR_W-1:0] boot_colors [DEFAULT_COLORS];
      boot_colors = '{16'hFFFF, 16'hFFE0, 16'hFD20, 16'hF800, 16'hEC1D, 16'h4810,
                      16'h001F, 16'h05FF, 16'h3666, 16'h0320, 16'h8A22, 16'hD5B1,
                      16'hD69A, 16'hAD55, 16'h6B4D, 16'h0000};
      foreach (color_table[i]) color_table[i] = '0;
      for (int i = 0; i < DEFAULT_COLORS && i < PALETTE_ENTRIES; i++) begin
        color_table[i] = boot_colors[i];
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // linear position of the next pixel the block will scan
    function int unsigned scan_pos();
      return scan_row * SCREEN_WIDTH + scan_col;
    endfunction

    function void note_command(in_item_t cmd);
      logic [IDX_W-1:0] idx;
      out_item_t        pix;
      case (opcode_e'(cmd.opcode))
        OP_DRAW: begin
          if (cmd.x < SCREEN_WIDTH && cmd.y < SCREEN_HEIGHT) begin
            frame_mem[cmd.y * SCREEN_WIDTH + cmd.x] = cmd.color_index;
          end
        end
        OP_PAL_WRITE: begin
          if (cmd.palette_index < PALETTE_ENTRIES) color_table[cmd.palette_index] = cmd.palette_color;
        end
        OP_PAL_CLEAR: begin
          foreach (color_table[i]) color_table[i] = '0;
        end
        OP_PAL_DEFAULT: begin
          load_default_palette();
        end
        OP_SCAN: begin
          if (scan_col >= SCREEN_WIDTH || scan_row >= SCREEN_HEIGHT) begin
            scan_col = '0;
            scan_row = '0;
          end
          idx = frame_mem[scan_pos()];
          pix.pixel_color = (idx < PALETTE_ENTRIES) ? color_table[idx] : '0;
          pix.row         = scan_row;
          pix.column      = scan_col;
          pix.row_start   = (scan_col == 0);
          pix.frame_end   = (scan_row == SCREEN_HEIGHT - 1) && (scan_col == SCREEN_WIDTH - 1);
          expected_pixels.push_back(pix);
          if (scan_col + 1 < SCREEN_WIDTH) begin
            scan_col = scan_col + 1'b1;
          end else begin
            scan_col = '0;
            scan_row = (scan_row + 1 < SCREEN_HEIGHT) ? scan_row + 1'b1 : '0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    task check_pixel(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel with nothing expected at row %0d col %0d",
                                  got.row, got.column));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_color !== want.pixel_color)
        report_mismatch($sformatf("pixel_color at %0d,%0d: got %h want %h",
                                  want.row, want.column, got.pixel_color, want.pixel_color));
      if (got.row !== want.row)
        report_mismatch($sformatf("row: got %0d want %0d", got.row, want.row));
      if (got.column !== want.column)
        report_mismatch($sformatf("column: got %0d want %0d", got.column, want.column));
      if (got.row_start !== want.row_start)
        report_mismatch($sformatf("row_start at %0d,%0d: got %b want %b",
                                  want.row, want.column, got.row_start, want.row_start));
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end at %0d,%0d: got %b want %b",
                                  want.row, want.column, got.frame_end, want.frame_end));
    endtask
  endclass

endpackage

@@ tb/tb_indexed_framebuffer_palette_scanout.sv @@
// testbench top for indexed_framebuffer_palette_scanout: directed and random commands,
// bursty sender, stalling receiver; depends on ifps_pkg, ifps_if and tb_ifps_scan_pkg
module tb_indexed_framebuffer_palette_scanout;
  import ifps_pkg::*;
  import tb_ifps_scan_pkg::*;

  localparam int WATCHDOG_LIMIT = 800000;  // covers the frame clearing pass after reset
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 160;
  localparam int FLOOD_SCANS    = 48;

  logic clk_i;
  logic rst_ni;
  logic fast_mode;
  logic hold_req;
  logic hold_active;
  int   burst_left;
  int   idle_cycles;

  scan_scoreboard sb;

  ifps_in_if  cmd_if ();
  ifps_out_if pix_if ();

  indexed_framebuffer_palette_scanout i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (pix_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic in_item_t mk_cmd(logic [OPC_W-1:0] op, int x, int y, int cidx,
                                      int pidx, int pcol);
    in_item_t cmd;
    cmd.opcode        = op;
    cmd.x             = XY_W'(x);
    cmd.y             = XY_W'(y);
    cmd.color_index   = IDX_W'(cidx);
    cmd.palette_index = IDX_W'(pidx);
    cmd.palette_color = COLOR_W'(pcol);
    return cmd;
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t    cmd;
    int unsigned pick;
    int unsigned pos;
    cmd.opcode        = OP_SCAN;
    cmd.x             = XY_W'($urandom());
    cmd.y             = XY_W'($urandom());
    cmd.color_index   = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 31)) : IDX_W'($urandom());
    cmd.palette_index = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 31)) : IDX_W'($urandom());
    cmd.palette_color = COLOR_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      cmd.opcode = OP_DRAW;
      // most draws land just ahead of the scan so they get read back soon
      if (pick < 28) begin
        pos   = (sb.scan_pos() + $urandom_range(0, 48)) % PIXEL_COUNT;
        cmd.x = XY_W'(pos % SCREEN_WIDTH);
        cmd.y = XY_W'(pos / SCREEN_WIDTH);
      end
    end else if (pick < 52) begin
      cmd.opcode = OP_PAL_WRITE;
    end else if (pick < 55) begin
      cmd.opcode = OP_PAL_CLEAR;
    end else if (pick < 58) begin
      cmd.opcode = OP_PAL_DEFAULT;
    end else if (pick < 62) begin
      cmd.opcode = OPC_W'($urandom_range(OP_SCAN + 1, 2 ** OPC_W - 1));
    end
    return cmd;
  endfunction

  // offer one command, honoring the burst/gap pattern, and return at its transfer edge
  task automatic send_cmd(input in_item_t cmd);
    int gap;
    if (burst_left == 0) begin
      burst_left = (fast_mode || $urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 12);
      gap = fast_mode ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    cmd_if.valid         <= 1'b1;
    cmd_if.opcode        <= cmd.opcode;
    cmd_if.x             <= cmd.x;
    cmd_if.y             <= cmd.y;
    cmd_if.color_index   <= cmd.color_index;
    cmd_if.palette_index <= cmd.palette_index;
    cmd_if.palette_color <= cmd.palette_color;
    do @(negedge clk_i); while (cmd_if.ready !== 1'b1);
    sb.note_command(cmd);
    @(posedge clk_i);
  endtask

  // drop valid so a finished command is not offered again
  task automatic idle_input();
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    idle_input();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // receiver: alternating ready/stall runs, long hold on request, always ready in fast mode
  initial begin
    int run_left;
    run_left     = 0;
    hold_active  = 1'b0;
    pix_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        pix_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
        pix_if.ready <= 1'b1;
        run_left = 8;
      end else if (fast_mode) begin
        pix_if.ready <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else if (pix_if.ready) begin
        pix_if.ready <= 1'b0;
        run_left = $urandom_range(0, 5);
      end else begin
        pix_if.ready <= 1'b1;
        run_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(0, 15);
      end
    end
  end

  // result monitor: sampled mid-cycle, the transfer happens at the next rising edge
  initial begin
    out_item_t got;
    forever begin
      @(negedge clk_i);
      if (rst_ni && pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
        got.pixel_color = pix_if.pixel_color;
        got.row         = pix_if.row;
        got.column      = pix_if.column;
        got.row_start   = pix_if.row_start;
        got.frame_end   = pix_if.frame_end;
        sb.check_pixel(got);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
          (pix_if.valid === 1'b1 && pix_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_item_t    directed_q [$];
    sb          = new();
    fast_mode   = 1'b0;
    hold_req    = 1'b0;
    burst_left  = 0;
    rst_ni      = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.opcode        = '0;
    cmd_if.x             = '0;
    cmd_if.y             = '0;
    cmd_if.color_index   = '0;
    cmd_if.palette_index = '0;
    cmd_if.palette_color = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, out of range draws, palette writes, clear and restore, unused opcodes
    directed_q.push_back(mk_cmd(OP_SCAN, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_cmd(OP_DRAW, 1, 0, 0, 0, 0));
    directed_q.push_back(mk_cmd(OP_DRAW, 2, 0, 255, 255, 16'hFFFF));
    directed_q.push_back(mk_cmd(OP_DRAW, 3, 0, 7, 0, 0));
    directed_q.push_back(mk_cmd(OP_DRAW, 319, 479, 3, 0, 0));
    directed_q.push_back(mk_cmd(OP_DRAW, 511, 511, 0, 0, 0));
    directed_q.push_back(mk_cmd(OP_DRAW, 320, 0, 1, 0, 0));
    directed_q.push_back(mk_cmd(OP_DRAW, 0, 480, 1, 0, 0));
    directed_q.push_back(mk_cmd(OP_DRAW, 4, 0, 14, 0, 0));
    directed_q.push_back(mk_cmd(OP_PAL_WRITE, 0, 0, 0, 255, 16'hFFFF));
    directed_q.push_back(mk_cmd(OP_PAL_WRITE, 511, 511, 255, 7, 16'h0000));
    directed_q.push_back(mk_cmd(OP_SCAN, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_cmd(OP_SCAN, 511, 511, 255, 255, 16'hFFFF));
    directed_q.push_back(mk_cmd(OP_SCAN, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_cmd(OP_PAL_CLEAR, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_cmd(OP_SCAN, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_cmd(OP_PAL_DEFAULT, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_cmd(OP_SCAN, 0, 0, 0, 0, 0));
    for (int op = OP_SCAN + 1; op < 2 ** OPC_W; op++) begin
      directed_q.push_back(mk_cmd(OPC_W'(op), 5, 0, 0, 15, 16'h5A5A));
    end
    directed_q.push_back(mk_cmd(OP_PAL_WRITE, 0, 0, 0, 15, 16'hA5A5));
    directed_q.push_back(mk_cmd(OP_SCAN, 0, 0, 0, 0, 0));
    foreach (directed_q[i]) send_cmd(directed_q[i]);

    repeat (RANDOM_ITEMS) send_cmd(random_cmd());

    // long receiver hold while scans keep coming, so the block backs up
    idle_input();
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk_i);
    repeat (FLOOD_SCANS) send_cmd(mk_cmd(OP_SCAN, 0, 0, 0, 0, 0));
    wait_drained();

    // receiver always ready and no gaps from the sender
    fast_mode = 1'b1;
    repeat (RANDOM_ITEMS) send_cmd(random_cmd());
    fast_mode = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ifps_pkg.sv
sv/ifps_if.sv
sv/ifps_ram.sv
sv/ifps_ctrl.sv
sv/ifps_dp.sv
sv/indexed_framebuffer_palette_scanout.sv
tb/tb_ifps_scan_pkg.sv
tb/tb_indexed_framebuffer_palette_scanout.sv
